// File: hw/rtl/pseudo_mersenne_modular_alu_assert.svh
// ---------------------------------------------------------------------------
// pseudo_mersenne_modular_alu assertion macros
// shared property forms, clocked on i_clk and held off during reset
// ---------------------------------------------------------------------------
`ifndef PSEUDO_MERSENNE_MODULAR_ALU_ASSERT_SVH
`define PSEUDO_MERSENNE_MODULAR_ALU_ASSERT_SVH

// same-cycle implication
`define PMA_ASSERT_NOW(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |-> (prop)) else $error(msg);

// next-cycle implication
`define PMA_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

// File: hw/rtl/pma_pkg.sv
// ---------------------------------------------------------------------------
// pma_pkg
// widths, kind codes and pipeline constants of the pseudo-Mersenne alu
// ---------------------------------------------------------------------------
package pma_pkg;

    localparam int OPERAND_W  = 63;
    localparam int RESIDUE_W  = 64;
    localparam int OFFSET_W   = 31;
    localparam int KIND_W     = 2;
    localparam int HALF_W     = 32;
    localparam int PROD_W     = 2 * OPERAND_W;
    localparam int FOLD1_W    = OPERAND_W + OFFSET_W;
    localparam int TDATA_W    = ((2 * OPERAND_W + 7) / 8) * 8;
    localparam int OUT_DATA_W = ((RESIDUE_W + 7) / 8) * 8;
    localparam int NUM_STAGES = 9;

    typedef logic [KIND_W-1:0]    t_kind;
    typedef logic [OFFSET_W-1:0]  t_offset;
    typedef logic [OPERAND_W-1:0] t_operand;
    typedef logic [RESIDUE_W-1:0] t_residue;

    localparam t_kind KIND_LAZY_ADD = 2'd0;
    localparam t_kind KIND_LAZY_MUL = 2'd1;
    localparam t_kind KIND_FULL_MUL = 2'd2;
    localparam t_kind KIND_UNUSED   = 2'd3;

    localparam t_offset OFFSET_RESET = 31'd1;

endpackage

// File: hw/rtl/pseudo_mersenne_modular_alu.sv
// ---------------------------------------------------------------------------
// pseudo_mersenne_modular_alu
// add and multiply modulo 2^63 - k with lazy or full reduction
// ---------------------------------------------------------------------------
// Takes one word per clock while the output side does not stall and returns
// one residue per word, in order. The 63 x 63 product is built from four
// multipliers (32 x 32, 32 x 31, 31 x 32, 31 x 31) and two adds over three
// stages, the first fold by k uses a 32 x 31 and a 31 x 31 multiplier and an
// add, the second fold one 31 x 31 multiplier, then a carry fold and a final
// conditional subtract of the modulus for kind 2. Each stage holds its word
// until the next one is free, so bubbles close up while the output waits and
// s_axis_tready follows m_axis_tready combinationally through the valid
// chain. The offset k is written on the cfg channel; the user must write it
// only while no word is in flight, which the block itself does not enforce.
// It resets to 1.
module pseudo_mersenne_modular_alu (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // config write channel: modulus offset k
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pma_pkg::OFFSET_W-1:0]  i_cfg_data,
    // input stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: operand_a [62:0], operand_b [125:63], zero [127:126]
    input  logic [pma_pkg::TDATA_W-1:0]   s_axis_tdata,
    // tuser: kind [1:0]
    input  logic [pma_pkg::KIND_W-1:0]    s_axis_tuser,
    // output stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // tdata: residue [63:0]
    output logic [pma_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import pma_pkg::*;

    localparam int LAST = NUM_STAGES - 1;

    // control
    t_offset               r_k;
    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_en;
    t_kind                 r_kind [NUM_STAGES];
    t_residue              r_sum  [6];

    // input unpack
    t_operand              in_a;
    t_operand              in_b;

    // stage 1: partial products
    logic [2*HALF_W-1:0]            r_s1_p00;
    logic [HALF_W+OPERAND_W-HALF_W-1:0] r_s1_p01;
    logic [HALF_W+OPERAND_W-HALF_W-1:0] r_s1_p10;
    logic [2*(OPERAND_W-HALF_W)-1:0]    r_s1_p11;
    // stage 2: middle sum
    logic [2*HALF_W-1:0]            r_s2_p00;
    logic [2*(OPERAND_W-HALF_W)-1:0] r_s2_p11;
    logic [2*HALF_W-1:0]            r_s2_mid;
    // stage 3: full product
    logic [PROD_W-1:0]              r_s3_prod;
    logic [PROD_W-1:0]              n_s3_prod;
    // stage 4: first fold partial products
    t_operand                       r_s4_lo;
    logic [HALF_W+OFFSET_W-1:0]     r_s4_t0;
    logic [OPERAND_W-HALF_W+OFFSET_W-1:0] r_s4_t1;
    // stage 5: first fold product
    t_operand                       r_s5_lo;
    logic [FOLD1_W-1:0]             r_s5_t;
    logic [FOLD1_W-1:0]             n_s5_t;
    // stage 6: low sum and second fold product
    t_residue                       r_s6_s;
    logic [2*OFFSET_W-1:0]          r_s6_q;
    // stage 7: pre-fold word
    logic [RESIDUE_W:0]             r_s7_w;
    logic [RESIDUE_W:0]             n_s7_w;
    // stage 8: folded residue
    t_residue                       r_s8_r;
    t_residue                       n_s8_r;
    logic [OFFSET_W+1:0]            carry_fold;
    // stage 9: output
    t_residue                       r_res;
    t_residue                       n_res;
    t_residue                       modulus;
    logic [RESIDUE_W:0]             diff;

    assign in_a = s_axis_tdata[OPERAND_W-1:0];
    assign in_b = s_axis_tdata[2*OPERAND_W-1:OPERAND_W];

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = stage_en[0];
    assign m_axis_tvalid = r_vld[LAST];
    assign m_axis_tdata  = OUT_DATA_W'(r_res);

    // a stage loads when empty or when its word moves on
    always_comb begin
        stage_en[LAST] = !r_vld[LAST] || m_axis_tready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_en[i] = !r_vld[i] || stage_en[i+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k   <= OFFSET_RESET;
            r_vld <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_k <= i_cfg_data;
            end
            if (stage_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int i = 1; i < NUM_STAGES; i++) begin
                if (stage_en[i]) begin
                    r_vld[i] <= r_vld[i-1];
                end
            end
        end
    end

    // kind and lazy-add sum travel alongside the product path
    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_kind[0] <= s_axis_tuser;
            r_sum[0]  <= {1'b0, in_a} + {1'b0, in_b};
        end
        for (int i = 1; i < NUM_STAGES; i++) begin
            if (stage_en[i]) begin
                r_kind[i] <= r_kind[i-1];
            end
        end
        for (int i = 1; i < 6; i++) begin
            if (stage_en[i]) begin
                r_sum[i] <= r_sum[i-1];
            end
        end
    end

    // 63 x 63 product: four partial products, middle sum, final add; also the first fold sum
    always_comb begin
        n_s3_prod = {r_s2_p11, r_s2_p00}
                  + {(PROD_W - 3 * HALF_W)'(0), r_s2_mid, HALF_W'(0)};
        n_s5_t    = {(FOLD1_W - HALF_W - OFFSET_W)'(0), r_s4_t0}
                  + {r_s4_t1, HALF_W'(0)};
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_p00 <= (2*HALF_W)'(in_a[HALF_W-1:0])
                      * (2*HALF_W)'(in_b[HALF_W-1:0]);
            r_s1_p01 <= OPERAND_W'(in_a[HALF_W-1:0])
                      * OPERAND_W'(in_b[OPERAND_W-1:HALF_W]);
            r_s1_p10 <= OPERAND_W'(in_a[OPERAND_W-1:HALF_W])
                      * OPERAND_W'(in_b[HALF_W-1:0]);
            r_s1_p11 <= (2*(OPERAND_W-HALF_W))'(in_a[OPERAND_W-1:HALF_W])
                      * (2*(OPERAND_W-HALF_W))'(in_b[OPERAND_W-1:HALF_W]);
        end
        if (stage_en[1]) begin
            r_s2_p00 <= r_s1_p00;
            r_s2_p11 <= r_s1_p11;
            r_s2_mid <= {1'b0, r_s1_p01} + {1'b0, r_s1_p10};
        end
        if (stage_en[2]) begin
            r_s3_prod <= n_s3_prod;
        end
        // first fold: high part of the product times k
        if (stage_en[3]) begin
            r_s4_lo <= r_s3_prod[OPERAND_W-1:0];
            r_s4_t0 <= (HALF_W+OFFSET_W)'(r_s3_prod[OPERAND_W+HALF_W-1:OPERAND_W])
                     * (HALF_W+OFFSET_W)'(r_k);
            r_s4_t1 <= (OPERAND_W-HALF_W+OFFSET_W)'(r_s3_prod[PROD_W-1:OPERAND_W+HALF_W])
                     * (OPERAND_W-HALF_W+OFFSET_W)'(r_k);
        end
        if (stage_en[4]) begin
            r_s5_lo <= r_s4_lo;
            r_s5_t  <= n_s5_t;
        end
        // second fold: bits 63 and up of the first fold times k
        if (stage_en[5]) begin
            r_s6_s <= {1'b0, r_s5_lo} + {1'b0, r_s5_t[OPERAND_W-1:0]};
            r_s6_q <= (2*OFFSET_W)'(r_s5_t[FOLD1_W-1:OPERAND_W]) * (2*OFFSET_W)'(r_k);
        end
        if (stage_en[6]) begin
            r_s7_w <= n_s7_w;
        end
        if (stage_en[7]) begin
            r_s8_r <= n_s8_r;
        end
        if (stage_en[8]) begin
            r_res <= n_res;
        end
    end

    // the add joins the multiply path here and shares the carry fold
    always_comb begin
        if (r_kind[5] == KIND_LAZY_ADD) begin
            n_s7_w = {1'b0, r_sum[5]};
        end else begin
            n_s7_w = {1'b0, r_s6_s} + {(RESIDUE_W + 1 - 2 * OFFSET_W)'(0), r_s6_q};
        end
    end

    always_comb begin
        carry_fold = (OFFSET_W+2)'(r_s7_w[RESIDUE_W:OPERAND_W]) * (OFFSET_W+2)'(r_k);
        n_s8_r     = {1'b0, r_s7_w[OPERAND_W-1:0]}
                   + {(RESIDUE_W - OFFSET_W - 2)'(0), carry_fold};
    end

    always_comb begin
        modulus = {1'b1, OPERAND_W'(0)} - {(RESIDUE_W - OFFSET_W)'(0), r_k};
        diff    = {1'b0, r_s8_r} - {1'b0, modulus};
        case (r_kind[7])
            KIND_LAZY_ADD, KIND_LAZY_MUL: begin
                n_res = r_s8_r;
            end
            KIND_FULL_MUL: begin
                n_res = diff[RESIDUE_W] ? r_s8_r : diff[RESIDUE_W-1:0];
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // checks
    logic [RESIDUE_W:0] lazy_bound;
    assign lazy_bound = {2'b01, OPERAND_W'(0)}
                      + {(RESIDUE_W - OFFSET_W - 1)'(0), r_k, 1'b0};

`include "pseudo_mersenne_modular_alu_assert.svh"

    `PMA_ASSERT_NOW(a_full_reduced, r_vld[LAST] && r_kind[LAST] == KIND_FULL_MUL, r_res < modulus, "kind 2 residue not below modulus")
    `PMA_ASSERT_NOW(a_lazy_bound, r_vld[LAST] && (r_kind[LAST] == KIND_LAZY_ADD || r_kind[LAST] == KIND_LAZY_MUL), ({1'b0, r_res} < lazy_bound), "lazy residue out of range")
    `PMA_ASSERT_NOW(a_unused_zero, r_vld[LAST] && r_kind[LAST] == KIND_UNUSED, r_res == '0, "unused kind gave nonzero residue")
    `PMA_ASSERT_NOW(a_full_backpressure, (&r_vld) && !m_axis_tready, !s_axis_tready, "full pipeline took a word")
    `PMA_ASSERT_NEXT(a_last_held, r_vld[LAST] && !m_axis_tready, r_vld[LAST] && $stable(r_kind[LAST]), "waiting word lost")

endmodule

// File: tb/tb_pseudo_mersenne_modular_alu.sv
// ---------------------------------------------------------------------------
// tb_pseudo_mersenne_modular_alu
// self-checking bench for the modulo 2^63 - k add / multiply unit
// ---------------------------------------------------------------------------
// Words go in on the input stream with random gaps. Each accepted word is
// run through a local predictor of the lazy and fully reduced folds at the
// offset in force, and the expected residue is queued. Every residue on the
// output stream is compared in order against that queue. The offset k is
// changed only with nothing in flight and covers 0, 1, 2^31-1 and random
// values. One test holds the output off long enough to fill the pipeline.
module tb_pseudo_mersenne_modular_alu;

    import pma_pkg::*;

    localparam t_operand OPERAND_MAX    = {OPERAND_W{1'b1}};
    localparam t_offset  OFFSET_MAX     = {OFFSET_W{1'b1}};
    localparam t_residue FOLD_BASE      = t_residue'(1) << OPERAND_W;
    localparam int       WATCHDOG_LIMIT = 2000;
    localparam int       HOLD_CYCLES    = 200;
    localparam int       PHASE_WORDS    = 200;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [OFFSET_W-1:0]   i_cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // tdata: operand_a [62:0], operand_b [125:63], zero [127:126]
    logic [TDATA_W-1:0]    s_axis_tdata;
    // tuser: kind [1:0]
    logic [KIND_W-1:0]     s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // tdata: residue [63:0]
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    t_residue expected_residues[$];
    t_residue next_residue;
    t_offset  mod_offset = OFFSET_RESET;
    bit       src_idle_on = 1'b1;
    bit       sink_idle_on = 1'b1;
    bit       hold_req = 1'b0;
    int       n_sent = 0;
    int       n_checked = 0;
    int       n_errors = 0;
    int       n_offsets = 1;
    int       stall_cycles = 0;

    pseudo_mersenne_modular_alu DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // residue of a + b or a * b folded by 2^63 - k
    function automatic t_residue predict_residue(t_kind kind, t_operand a, t_operand b,
                                                 t_offset k);
        logic [RESIDUE_W-1:0] sum;
        logic [PROD_W-1:0]    prod;
        logic [FOLD1_W-1:0]   fold1;
        logic [OPERAND_W+1:0] fold2;
        t_residue             lazy;
        sum   = {1'b0, a} + {1'b0, b};
        prod  = {{OPERAND_W{1'b0}}, a} * {{OPERAND_W{1'b0}}, b};
        fold1 = prod[PROD_W-1:OPERAND_W] * k;
        fold2 = prod[OPERAND_W-1:0] + fold1[OPERAND_W-1:0] + fold1[FOLD1_W-1:OPERAND_W] * k;
        lazy  = fold2[OPERAND_W-1:0] + fold2[OPERAND_W+1:OPERAND_W] * k;
        case (kind)
            KIND_LAZY_ADD: begin
                return sum[OPERAND_W-1:0] + sum[OPERAND_W] * k;
            end
            KIND_LAZY_MUL: begin
                return lazy;
            end
            KIND_FULL_MUL: begin
                return (lazy >= FOLD_BASE - k) ? lazy - (FOLD_BASE - k) : lazy;
            end
            default: begin
                return '0;
            end
        endcase
    endfunction

    function automatic t_operand rand_operand(t_offset k);
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 7))
            2: raw = 64'($urandom_range(0, 255));
            3: raw = OPERAND_MAX - $urandom_range(0, 255);
            // lands in [M, 2^63), so a times 1 needs the final subtract
            4: if (k != 0) raw = FOLD_BASE - k + $urandom_range(0, k - 1);
            5: raw = 64'd1 << $urandom_range(0, OPERAND_W - 1);
            6: raw = raw | 64'h7FFF_FFFF_0000_0000;
            7: raw = 64'd1;
            default: ;
        endcase
        return raw[OPERAND_W-1:0];
    endfunction

    function automatic t_kind random_kind();
        if ($urandom_range(0, 15) == 0)
            return KIND_UNUSED;
        return t_kind'($urandom_range(0, 2));
    endfunction

    task automatic send_word(input t_kind kind, input t_operand a, input t_operand b);
        int unsigned gap;
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, b, a};
        s_axis_tuser  <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_residues.push_back(predict_residue(kind, a, b, mod_offset));
        n_sent++;
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_residues.size() != 0) @(posedge i_clk);
        repeat (NUM_STAGES + 4) @(posedge i_clk);
    endtask

    // only called with nothing in flight
    task automatic write_modulus_offset(input t_offset k);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= k;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mod_offset = k;
        n_offsets++;
    endtask

    task automatic test_reset_offset();
        send_word(KIND_LAZY_ADD, '0, '0);
        send_word(KIND_LAZY_ADD, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_LAZY_ADD, OPERAND_MAX, 63'd1);
        send_word(KIND_LAZY_MUL, '0, OPERAND_MAX);
        send_word(KIND_LAZY_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, OPERAND_MAX, 63'd1);
        send_word(KIND_FULL_MUL, 63'd1, OPERAND_MAX - 63'd1);
        send_word(KIND_UNUSED, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_UNUSED, '0, '0);
        wait_idle();
    endtask

    task automatic test_offset_extremes();
        t_residue modulus;
        write_modulus_offset(OFFSET_MAX);
        modulus = FOLD_BASE - OFFSET_MAX;
        send_word(KIND_LAZY_ADD, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_LAZY_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, 63'd1, modulus[OPERAND_W-1:0]);
        send_word(KIND_FULL_MUL, OPERAND_MAX, 63'd1);
        send_word(KIND_UNUSED, OPERAND_MAX, 63'd1);
        wait_idle();
        // offset zero: modulus is 2^63 and the folds drop the high part
        write_modulus_offset('0);
        send_word(KIND_LAZY_ADD, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_LAZY_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, OPERAND_MAX, OPERAND_MAX);
        send_word(KIND_FULL_MUL, 63'd1, OPERAND_MAX);
        wait_idle();
    endtask

    task automatic test_random_stream(input t_offset k, input int count);
        write_modulus_offset(k);
        repeat (count) send_word(random_kind(), rand_operand(k), rand_operand(k));
        wait_idle();
    endtask

    task automatic test_output_stall();
        src_idle_on = 1'b0;
        hold_req = 1'b1;
        repeat (60) send_word(random_kind(), rand_operand(mod_offset), rand_operand(mod_offset));
        src_idle_on = 1'b1;
        wait_idle();
    endtask

    task automatic test_full_rate();
        t_offset k;
        k = t_offset'($urandom_range(1, OFFSET_MAX));
        src_idle_on = 1'b0;
        sink_idle_on = 1'b0;
        test_random_stream(k, 500);
    endtask

    // receiver: random ready bursts, one long hold when asked
    initial begin
        forever begin
            if (hold_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (sink_idle_on && $urandom_range(0, 4) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge i_clk);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_residues.size() == 0) begin
                $display("%0t: residue %h with nothing expected", $time, m_axis_tdata);
                n_errors++;
            end else begin
                next_residue = expected_residues.pop_front();
                n_checked++;
                if (m_axis_tdata !== next_residue) begin
                    $display("%0t: residue mismatch, expected %h actual %h",
                             $time, next_residue, m_axis_tdata);
                    n_errors++;
                end
            end
        end
    end

    // ends the run if no word moves on any channel for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
                || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog, no word moved for %0d cycles", $time, stall_cycles);
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_offset();
        test_offset_extremes();
        test_random_stream(t_offset'($urandom_range(1, OFFSET_MAX)), PHASE_WORDS);
        test_random_stream(OFFSET_MAX, PHASE_WORDS);
        test_random_stream(t_offset'($urandom_range(1, 255)), PHASE_WORDS);
        test_random_stream('0, PHASE_WORDS);
        test_random_stream(t_offset'($urandom_range(1, OFFSET_MAX)), PHASE_WORDS);
        test_random_stream(OFFSET_RESET, PHASE_WORDS);
        test_output_stall();
        test_full_rate();

        if (expected_residues.size() != 0) begin
            $display("%0t: %0d residues never arrived", $time, expected_residues.size());
            n_errors++;
        end
        $display("covered %0d words, all four kinds, over %0d offset settings incl. 0, 1, max",
                 n_sent, n_offsets);
        $display("%0d residues checked, %0d errors, one long output hold", n_checked, n_errors);
        if (n_errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
